>>> hdl/tcop_pkg.sv
// ----------------------------------------------------------------------------
// tcop_pkg
// Shared types, constants and the constant trig function of the circle
// point generator.
// ----------------------------------------------------------------------------
package tcop_pkg;

    localparam int unsigned LAST_STEP_DEF     = 225;
    localparam int unsigned FRACTION_BITS_DEF = 16;

    localparam int unsigned ANGLE_W  = 8;
    localparam int unsigned RADIUS_W = 10;
    localparam int unsigned COORD_W  = 11;
    localparam int unsigned TAB_N    = 1 << ANGLE_W;
    localparam int unsigned QUEUE_DEPTH = 2;

    // pi/900 in Q30, one angle step of 0.2 degrees
    localparam longint unsigned ANGLE_UNIT_Q30 = 64'd3748066;
    localparam longint          ONE_Q30        = 64'sd1 << 30;

    typedef enum logic [2:0] {
        OCT_XY   = 3'd0,
        OCT_YX   = 3'd1,
        OCT_NYX  = 3'd2,
        OCT_NXY  = 3'd3,
        OCT_NXNY = 3'd4,
        OCT_NYNX = 3'd5,
        OCT_YNX  = 3'd6,
        OCT_XNY  = 3'd7
    } octant_t;

    // cosine or sine of k steps, Taylor series in Q30, rounded to fb bits
    // only evaluated at elaboration to build the lookup table
    function automatic logic [31:0] trig_frac(input int unsigned k, input int unsigned fb,
                                              input logic want_sin);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] term;
        logic [63:0] u;
        longint      s;
        longint      c;
        longint      v;
        t    = 64'(k) * ANGLE_UNIT_Q30;
        t2   = (t * t) >> 30;
        term = t;
        s    = longint'(term);
        for (int n = 1; n <= 7; n++)
        begin
            term = ((term * t2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n & 1) != 0)
                s = s - longint'(term);
            else
                s = s + longint'(term);
        end
        term = 64'(ONE_Q30);
        c    = ONE_Q30;
        for (int n = 1; n <= 8; n++)
        begin
            term = ((term * t2) >> 30) / 64'((2 * n - 1) * (2 * n));
            if ((n & 1) != 0)
                c = c - longint'(term);
            else
                c = c + longint'(term);
        end
        v = want_sin ? s : c;
        if (v < 0)
            v = 0;
        if (v > ONE_Q30)
            v = ONE_Q30;
        u = 64'(v);
        u = (u + (64'd1 << (29 - fb))) >> (30 - fb);
        return u[31:0];
    endfunction

endpackage

>>> hdl/tcop_front.sv
// ----------------------------------------------------------------------------
// tcop_front
// Takes angle words, saturates the step index and looks up the rounded
// cosine and sine in a constant table; one registered stage toward the queue.
// ----------------------------------------------------------------------------
module tcop_front #(
    parameter int unsigned LAST_STEP     = tcop_pkg::LAST_STEP_DEF,
    parameter int unsigned FRACTION_BITS = tcop_pkg::FRACTION_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  logic [tcop_pkg::ANGLE_W-1:0]        angle_step,
    output logic                                full,
    output logic                                q_push,
    output logic [2*(FRACTION_BITS+1)-1:0]      q_data,
    input  logic                                q_full
);

    localparam int unsigned VAL_W = FRACTION_BITS + 1;
    localparam int unsigned MAX_IDX = tcop_pkg::TAB_N - 1;
    localparam logic [tcop_pkg::ANGLE_W-1:0] SAT_STEP =
        tcop_pkg::ANGLE_W'((LAST_STEP > MAX_IDX) ? MAX_IDX : LAST_STEP);

    logic [VAL_W-1:0] cos_tab [tcop_pkg::TAB_N];
    logic [VAL_W-1:0] sin_tab [tcop_pkg::TAB_N];

    for (genvar i = 0; i < tcop_pkg::TAB_N; i++)
    begin : g_tab
        assign cos_tab[i] = VAL_W'(tcop_pkg::trig_frac(i, FRACTION_BITS, 1'b0));
        assign sin_tab[i] = VAL_W'(tcop_pkg::trig_frac(i, FRACTION_BITS, 1'b1));
    end

    logic                        valid_reg;
    logic                        valid_next;
    logic [VAL_W-1:0]            cos_reg;
    logic [VAL_W-1:0]            sin_reg;
    logic [tcop_pkg::ANGLE_W-1:0] step_sat;
    logic                        in_ready;
    logic                        accept;

    assign step_sat = (angle_step > SAT_STEP) ? SAT_STEP : angle_step;
    assign in_ready = !valid_reg || !q_full;
    assign accept   = push && in_ready;
    assign full     = !in_ready;
    assign q_push   = valid_reg && !q_full;
    assign q_data   = {cos_reg, sin_reg};

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (q_push)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cos_reg <= cos_tab[step_sat];
            sin_reg <= sin_tab[step_sat];
        end
    end

endmodule

>>> hdl/tcop_fifo.sv
// ----------------------------------------------------------------------------
// tcop_fifo
// Short queue between the lookup front and the point sequencer.
// ----------------------------------------------------------------------------
module tcop_fifo #(
    parameter int unsigned DATA_W = 2 * (tcop_pkg::FRACTION_BITS_DEF + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [DATA_W-1:0] wr_data,
    output logic              full,
    input  logic              rd_en,
    output logic [DATA_W-1:0] rd_data,
    output logic              empty
);

    localparam int unsigned DEPTH = tcop_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_wr;
    logic              do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + CNT_W'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

>>> hdl/tcop_back.sv
// ----------------------------------------------------------------------------
// tcop_back
// Scales cosine and sine by the radius with rounding, then walks the eight
// symmetric copies of the point out through the result register.
// ----------------------------------------------------------------------------
module tcop_back #(
    parameter int unsigned FRACTION_BITS = tcop_pkg::FRACTION_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_empty,
    input  logic [2*(FRACTION_BITS+1)-1:0]       q_data,
    output logic                                 q_pop,
    input  logic [tcop_pkg::RADIUS_W-1:0]        radius,
    output logic signed [tcop_pkg::COORD_W-1:0]  point_x,
    output logic signed [tcop_pkg::COORD_W-1:0]  point_y,
    output logic [2:0]                           octant,
    output logic                                 last_point,
    output logic                                 empty,
    input  logic                                 pop
);

    localparam int unsigned VAL_W  = FRACTION_BITS + 1;
    localparam int unsigned PROD_W = tcop_pkg::RADIUS_W + VAL_W + 1;
    localparam int unsigned R_W    = tcop_pkg::RADIUS_W;
    localparam int unsigned C_W    = tcop_pkg::COORD_W;
    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRACTION_BITS - 1);

    logic [VAL_W-1:0]  q_cos;
    logic [VAL_W-1:0]  q_sin;
    logic [PROD_W-1:0] prod_x;
    logic [PROD_W-1:0] prod_y;

    logic              mul_valid_reg;
    logic              mul_valid_next;
    logic [R_W-1:0]    mx_reg;
    logic [R_W-1:0]    my_reg;

    logic              em_valid_reg;
    logic              em_valid_next;
    tcop_pkg::octant_t oct_reg;
    tcop_pkg::octant_t oct_next;
    logic [R_W-1:0]    ex_reg;
    logic [R_W-1:0]    ey_reg;

    logic              out_pop;
    logic              em_take;
    logic              em_load;
    logic              mul_take;
    logic signed [C_W-1:0] px;
    logic signed [C_W-1:0] py;
    logic signed [C_W-1:0] nx;
    logic signed [C_W-1:0] ny;

    assign q_cos  = q_data[2*VAL_W-1:VAL_W];
    assign q_sin  = q_data[VAL_W-1:0];
    // product rounded half up, the integer part lands in the radius width
    assign prod_x = PROD_W'(radius) * PROD_W'(q_cos) + HALF;
    assign prod_y = PROD_W'(radius) * PROD_W'(q_sin) + HALF;

    assign out_pop  = pop && em_valid_reg;
    assign em_take  = !em_valid_reg || (out_pop && oct_reg == tcop_pkg::OCT_XNY);
    assign em_load  = em_take && mul_valid_reg;
    assign mul_take = !mul_valid_reg || em_load;
    assign q_pop    = !q_empty && mul_take;

    always_comb
    begin
        mul_valid_next = mul_valid_reg;
        if (q_pop)
            mul_valid_next = 1'b1;
        else if (em_load)
            mul_valid_next = 1'b0;
    end

    always_comb
    begin
        em_valid_next = em_valid_reg;
        oct_next      = oct_reg;
        if (em_load)
        begin
            em_valid_next = 1'b1;
            oct_next      = tcop_pkg::OCT_XY;
        end
        else if (out_pop)
        begin
            if (oct_reg == tcop_pkg::OCT_XNY)
                em_valid_next = 1'b0;
            else
                oct_next = tcop_pkg::octant_t'(oct_reg + 3'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            em_valid_reg  <= 1'b0;
            oct_reg       <= tcop_pkg::OCT_XY;
        end
        else
        begin
            mul_valid_reg <= mul_valid_next;
            em_valid_reg  <= em_valid_next;
            oct_reg       <= oct_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            mx_reg <= prod_x[FRACTION_BITS +: R_W];
            my_reg <= prod_y[FRACTION_BITS +: R_W];
        end
        if (em_load)
        begin
            ex_reg <= mx_reg;
            ey_reg <= my_reg;
        end
    end

    assign px = signed'({1'b0, ex_reg});
    assign py = signed'({1'b0, ey_reg});
    assign nx = -px;
    assign ny = -py;

    always_comb
    begin
        case (oct_reg)
            tcop_pkg::OCT_XY:   begin point_x = px; point_y = py; end
            tcop_pkg::OCT_YX:   begin point_x = py; point_y = px; end
            tcop_pkg::OCT_NYX:  begin point_x = ny; point_y = px; end
            tcop_pkg::OCT_NXY:  begin point_x = nx; point_y = py; end
            tcop_pkg::OCT_NXNY: begin point_x = nx; point_y = ny; end
            tcop_pkg::OCT_NYNX: begin point_x = ny; point_y = nx; end
            tcop_pkg::OCT_YNX:  begin point_x = py; point_y = nx; end
            tcop_pkg::OCT_XNY:  begin point_x = px; point_y = ny; end
            default:            begin point_x = px; point_y = py; end
        endcase
    end

    assign octant     = oct_reg;
    assign last_point = (oct_reg == tcop_pkg::OCT_XNY);
    assign empty      = !em_valid_reg;

endmodule

>>> hdl/trig_circle_octant_points.sv
// ----------------------------------------------------------------------------
// trig_circle_octant_points
// Circle point generator: one angle word in, eight symmetric points out.
// ----------------------------------------------------------------------------
// Input channel: drive angle_step (0.2 degree steps) with push; the word is
// taken on a clock edge with push high and full low. Steps above LAST_STEP
// are treated as LAST_STEP.
// Result channel: while empty is low the oldest point sits on point_x,
// point_y, octant and last_point; pop takes it. Each angle gives eight
// points in octant order 0..7, last_point marks the eighth.
// Path: the first point of an angle passes the table lookup, registered on
// the taking edge, then the queue, the radius multiply register and the
// result register before it shows on the result channel.
// Throughput: one point per cycle while the receiver keeps pop high, set by
// the single result port; a two-entry queue sits between the lookup and the
// sequencer so new angles are taken while points are still going out.
// radius is written over APB at address 0; the user must write it only
// while idle, the block does not enforce it. Reset clears the radius to 0
// and drops every word in flight. If the receiver holds off pop, points
// wait and full rises once the queue and the lookup stage are occupied.
// ----------------------------------------------------------------------------
module trig_circle_octant_points #(
    parameter int unsigned LAST_STEP     = tcop_pkg::LAST_STEP_DEF,
    parameter int unsigned FRACTION_BITS = tcop_pkg::FRACTION_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [2:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    input  logic                                 push,
    input  logic [tcop_pkg::ANGLE_W-1:0]         angle_step,
    output logic                                 full,
    output logic signed [tcop_pkg::COORD_W-1:0]  point_x,
    output logic signed [tcop_pkg::COORD_W-1:0]  point_y,
    output logic [2:0]                           octant,
    output logic                                 last_point,
    output logic                                 empty,
    input  logic                                 pop
);

    localparam int unsigned DATA_W = 2 * (FRACTION_BITS + 1);
    localparam logic REG_RADIUS = 1'b0;

    logic [tcop_pkg::RADIUS_W-1:0] radius_reg;
    logic [tcop_pkg::RADIUS_W-1:0] radius_next;
    logic                          cfg_wr;

    logic              fq_push;
    logic [DATA_W-1:0] fq_data;
    logic              fq_full;
    logic              bq_pop;
    logic [DATA_W-1:0] bq_data;
    logic              bq_empty;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_RADIUS) ? 32'(radius_reg) : 32'd0;

    always_comb
    begin
        radius_next = radius_reg;
        if (cfg_wr && paddr[2] == REG_RADIUS)
            radius_next = pwdata[tcop_pkg::RADIUS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= '0;
        else
            radius_reg <= radius_next;
    end

    tcop_front #(
        .LAST_STEP     (LAST_STEP),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .angle_step (angle_step),
        .full       (full),
        .q_push     (fq_push),
        .q_data     (fq_data),
        .q_full     (fq_full)
    );

    tcop_fifo #(
        .DATA_W (DATA_W)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fq_push),
        .wr_data (fq_data),
        .full    (fq_full),
        .rd_en   (bq_pop),
        .rd_data (bq_data),
        .empty   (bq_empty)
    );

    tcop_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (bq_empty),
        .q_data     (bq_data),
        .q_pop      (bq_pop),
        .radius     (radius_reg),
        .point_x    (point_x),
        .point_y    (point_y),
        .octant     (octant),
        .last_point (last_point),
        .empty      (empty),
        .pop        (pop)
    );

`ifndef SYNTHESIS
    // octants of one angle follow each other with no gap in the count
    a_octant_step: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last_point) |=>
            (!empty && octant == 3'($past(octant) + 3'd1)))
        else $error("octant sequence broken");

    // after the last point the next word, if any, starts a new angle
    a_new_angle: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && last_point) |=> (empty || octant == tcop_pkg::OCT_XY))
        else $error("new angle does not start at octant 0");

    // the second copy swaps the coordinates of the first
    a_swap: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && octant == tcop_pkg::OCT_XY) |=>
            (point_x == $past(point_y) && point_y == $past(point_x)))
        else $error("second point is not the swapped first point");
`endif

endmodule

>>> tb/tb_trig_circle_octant_points.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trig_circle_octant_points
// Self-checking bench for the circle point generator. Angle words go in
// through a queue-fed driver and every point that comes out is compared with
// the eight symmetric points worked out from a Q30 Taylor evaluation of cos
// and sin. The radius is changed over APB between phases and read back.
// ----------------------------------------------------------------------------
module tb_trig_circle_octant_points;

    localparam logic [2:0]  RADIUS_ADDR   = 3'd0;
    localparam logic [2:0]  UNMAPPED_ADDR = 3'd4;
    localparam int unsigned FB            = tcop_pkg::FRACTION_BITS_DEF;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int          N_PHASES      = 6;
    localparam int          PHASE_ANGLES  = 60;

    typedef struct {
        logic signed [tcop_pkg::COORD_W-1:0] x;
        logic signed [tcop_pkg::COORD_W-1:0] y;
        tcop_pkg::octant_t                   oct;
        logic                                last;
    } circle_point_t;

    logic                                clk        = 1'b0;
    logic                                rst_n      = 1'b0;
    logic                                psel       = 1'b0;
    logic                                penable    = 1'b0;
    logic                                pwrite     = 1'b0;
    logic [2:0]                          paddr      = '0;
    logic [31:0]                         pwdata     = '0;
    logic [31:0]                         prdata;
    logic                                pready;
    logic                                push       = 1'b0;
    logic [tcop_pkg::ANGLE_W-1:0]        angle_step = '0;
    logic                                full;
    logic signed [tcop_pkg::COORD_W-1:0] point_x;
    logic signed [tcop_pkg::COORD_W-1:0] point_y;
    logic [2:0]                          octant;
    logic                                last_point;
    logic                                empty;
    logic                                pop        = 1'b0;

    circle_point_t                 expected_points[$];
    logic [tcop_pkg::ANGLE_W-1:0]  pending_angles[$];
    logic [tcop_pkg::RADIUS_W-1:0] radius_now    = '0;
    int                            errors        = 0;
    int                            angles_sent   = 0;
    int                            points_seen   = 0;
    int                            radius_writes = 0;
    int                            push_gap_pct  = 0;
    int                            pop_stall_pct = 0;
    int                            push_idle     = 0;
    int                            pop_idle      = 0;
    int unsigned                   cycles        = 0;

    trig_circle_octant_points u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .push       (push),
        .angle_step (angle_step),
        .full       (full),
        .point_x    (point_x),
        .point_y    (point_y),
        .octant     (octant),
        .last_point (last_point),
        .empty      (empty),
        .pop        (pop)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // clamp a Q30 series sum to [0, 1] and round half up to FB fraction bits
    function automatic logic [63:0] unit_to_frac(input longint sum);
        logic [63:0] v;
        if (sum < 0)
            sum = 0;
        if (sum > tcop_pkg::ONE_Q30)
            sum = tcop_pkg::ONE_Q30;
        v = 64'(sum);
        return (v + (64'd1 << (29 - FB))) >> (30 - FB);
    endfunction

    // rounded r*cos and r*sin for one angle index
    function automatic void circle_xy(input logic [tcop_pkg::ANGLE_W-1:0] step,
                                      input logic [tcop_pkg::RADIUS_W-1:0] r,
                                      output logic signed [tcop_pkg::COORD_W-1:0] x,
                                      output logic signed [tcop_pkg::COORD_W-1:0] y);
        logic [63:0] ang;
        logic [63:0] ang_sq;
        logic [63:0] term;
        logic [63:0] cos_f;
        logic [63:0] sin_f;
        logic [63:0] x_full;
        logic [63:0] y_full;
        longint      sin_sum;
        longint      cos_sum;
        int unsigned k;
        k       = (step > tcop_pkg::LAST_STEP_DEF) ? tcop_pkg::LAST_STEP_DEF : int'(step);
        ang     = 64'(k) * tcop_pkg::ANGLE_UNIT_Q30;
        ang_sq  = (ang * ang) >> 30;
        term    = ang;
        sin_sum = longint'(term);
        for (int n = 1; n <= 7; n++)
        begin
            term = ((term * ang_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
            sin_sum = (n % 2 == 1) ? sin_sum - longint'(term) : sin_sum + longint'(term);
        end
        term    = 64'd1 << 30;
        cos_sum = tcop_pkg::ONE_Q30;
        for (int n = 1; n <= 8; n++)
        begin
            term = ((term * ang_sq) >> 30) / 64'((2 * n - 1) * (2 * n));
            cos_sum = (n % 2 == 1) ? cos_sum - longint'(term) : cos_sum + longint'(term);
        end
        cos_f  = unit_to_frac(cos_sum);
        sin_f  = unit_to_frac(sin_sum);
        x_full = (64'(r) * cos_f + (64'd1 << (FB - 1))) >> FB;
        y_full = (64'(r) * sin_f + (64'd1 << (FB - 1))) >> FB;
        x = x_full[tcop_pkg::COORD_W-1:0];
        y = y_full[tcop_pkg::COORD_W-1:0];
    endfunction

    task automatic add_octant_points(input logic [tcop_pkg::ANGLE_W-1:0] step);
        logic signed [tcop_pkg::COORD_W-1:0] x;
        logic signed [tcop_pkg::COORD_W-1:0] y;
        circle_point_t                       pt;
        circle_xy(step, radius_now, x, y);
        for (int i = 0; i < 8; i++)
        begin
            pt.oct = tcop_pkg::octant_t'(i);
            case (pt.oct)
                tcop_pkg::OCT_XY:   begin pt.x = x;  pt.y = y;  end
                tcop_pkg::OCT_YX:   begin pt.x = y;  pt.y = x;  end
                tcop_pkg::OCT_NYX:  begin pt.x = -y; pt.y = x;  end
                tcop_pkg::OCT_NXY:  begin pt.x = -x; pt.y = y;  end
                tcop_pkg::OCT_NXNY: begin pt.x = -x; pt.y = -y; end
                tcop_pkg::OCT_NYNX: begin pt.x = -y; pt.y = -x; end
                tcop_pkg::OCT_YNX:  begin pt.x = y;  pt.y = -x; end
                default:            begin pt.x = x;  pt.y = -y; end
            endcase
            pt.last = (pt.oct == tcop_pkg::OCT_XNY);
            expected_points.push_back(pt);
        end
    endtask

    task automatic report_field(input string name, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // APB write, then read the radius back
    task automatic apb_write_readback(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == RADIUS_ADDR)
            radius_now = data[tcop_pkg::RADIUS_W-1:0];
        radius_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        paddr   <= RADIUS_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== 32'(radius_now))
        begin
            errors++;
            $display("%0t: radius readback mismatch, expected %0d, actual %0d",
                     $time, radius_now, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // wait until every queued word is taken and every point has come out
    task automatic drain_all();
        @(negedge clk);
        while (pending_angles.size() != 0 || push || expected_points.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // angle driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push       <= 1'b0;
            angle_step <= '0;
            push_idle  = 0;
        end
        else
        begin
            if (push && !full)
            begin
                add_octant_points(angle_step);
                angles_sent++;
            end
            if (!(push && full))
            begin
                if (push_idle > 0)
                begin
                    push_idle--;
                    push <= 1'b0;
                end
                else if (pending_angles.size() == 0)
                    push <= 1'b0;
                else if ($urandom_range(99) < push_gap_pct)
                begin
                    push_idle = $urandom_range(0, 9);
                    push <= 1'b0;
                end
                else
                begin
                    push       <= 1'b1;
                    angle_step <= pending_angles.pop_front();
                end
            end
        end
    end

    // point monitor and pop control
    always @(posedge clk or negedge rst_n)
    begin : point_monitor
        circle_point_t want;
        if (!rst_n)
        begin
            pop      <= 1'b0;
            pop_idle = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                points_seen++;
                if (expected_points.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected point, expected none, actual x=%0d y=%0d oct=%0d",
                             $time, point_x, point_y, octant);
                end
                else
                begin
                    want = expected_points.pop_front();
                    report_field("point_x", want.x, point_x);
                    report_field("point_y", want.y, point_y);
                    report_field("octant", int'(want.oct), int'(octant));
                    report_field("last_point", int'(want.last), int'(last_point));
                end
            end
            if (pop_idle > 0)
            begin
                pop_idle--;
                pop <= 1'b0;
            end
            else if ($urandom_range(99) < pop_stall_pct)
            begin
                pop_idle = $urandom_range(0, 9);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d points outstanding", $time, expected_points.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] radius_words[N_PHASES];
        int          gap_pcts[N_PHASES];
        int          stall_pcts[N_PHASES];
        logic [7:0]  full_radius_angles[$];
        radius_words = '{32'hFFFF_FFFF, 32'h0000_0001, $urandom, 32'h0000_0000,
                         32'h0000_0200, $urandom};
        gap_pcts     = '{20, 10, 30, 5, 15, 0};
        stall_pcts   = '{10, 30, 5, 20, 15, 0};
        full_radius_angles = '{8'd0, 8'd1, 8'd2, 8'd45, 8'd64, 8'd85, 8'd112, 8'd113,
                               8'd127, 8'd128, 8'd150, 8'd200, 8'd224, 8'd225, 8'd226,
                               8'd255};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // radius still at its reset value of zero
        pending_angles = '{8'd0, 8'd100, 8'd225, 8'd255};
        drain_all();

        // full radius, back to back, including indexes past the last step
        apb_write_readback(RADIUS_ADDR, 32'h0000_03FF);
        foreach (full_radius_angles[i])
            pending_angles.push_back(full_radius_angles[i]);
        drain_all();

        // write to an unmapped register must leave the radius alone
        apb_write_readback(UNMAPPED_ADDR, $urandom);
        pending_angles = '{8'd75, 8'd190};
        push_gap_pct  = 25;
        pop_stall_pct = 25;
        drain_all();

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            apb_write_readback(RADIUS_ADDR, radius_words[ph]);
            push_gap_pct  = gap_pcts[ph];
            pop_stall_pct = stall_pcts[ph];
            for (int i = 0; i < PHASE_ANGLES; i++)
                pending_angles.push_back(8'($urandom_range(0, 255)));
            drain_all();
        end

        $display("sent %0d angle words over %0d register writes, checked %0d points",
                 angles_sent, radius_writes, points_seen);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
hdl/tcop_pkg.sv
hdl/tcop_front.sv
hdl/tcop_fifo.sv
hdl/tcop_back.sv
hdl/trig_circle_octant_points.sv
tb/tb_trig_circle_octant_points.sv
